// ----- design/iarl_pkg.sv -----
// iarl_pkg: shared types and codes for the indexed array list
// used by iarl_cell and indexed_array_list, depends on nothing
`default_nettype none

package iarl_pkg;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_PREPEND = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int POS_W = 5;
  localparam int LEN_W = 5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] data_value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [LEN_W-1:0]   list_length;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/iarl_cell.sv -----
// iarl_cell: one slot of the list, shifts with its neighbors on insert and remove
// depends on iarl_pkg
`default_nettype none

module iarl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  iarl_pkg::cell_ctl_t     ctl,
  input  wire [CW-1:0]            at,
  input  wire [CW-1:0]            cnt,
  input  wire signed [31:0]       word,
  input  wire signed [31:0]       lower_val,
  input  wire signed [31:0]       upper_val,
  output logic signed [31:0]      val
);

  localparam logic [CW-1:0] ME  = CW'(IDX);
  localparam logic [CW-1:0] ME1 = CW'(IDX + 1);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (ME == at) begin
        val_nxt = word;
      end else if (ME > at && ME <= cnt) begin
        val_nxt = lower_val;
      end
    end else if (ctl.rem) begin
      if (ME >= at && ME1 < cnt) begin
        val_nxt = upper_val;
      end else if (ME1 == cnt) begin
        val_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ----- design/indexed_array_list.sv -----
// indexed_array_list: fixed-capacity ordered list of signed words built as a row of cells
// depends on iarl_pkg and iarl_cell
//
//   port group  dir  word type              meaning
//   in_*        in   iarl_pkg::in_word_t    opcode, data_value, position
//   out_*       out  iarl_pkg::out_word_t   status, read_value, list_length
//
// one word per clock unless in_stall is high; the whole cell row shifts as it is taken
// the result is written into the output register as the word is taken
// reset (rst_n low, synchronous) empties the list and clears every cell to zero
// in_stall rises only while a finished result is held and out_stall is high
`default_nettype none

module indexed_array_list #(
  parameter int CAPACITY = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  iarl_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output iarl_pkg::out_word_t  out_data
);

  // count width holds 0..CAPACITY, compare width also covers the 5-bit position
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > iarl_pkg::POS_W) ? CW : iarl_pkg::POS_W;
  localparam int RD_N = (CAPACITY < 32) ? CAPACITY : 32;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  iarl_pkg::out_word_t  out_data_r;
  iarl_pkg::out_word_t  out_data_nxt;

  logic                 accept;
  logic                 full;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic [CW-1:0]        at;
  iarl_pkg::cell_ctl_t  ctl;
  logic signed [31:0]   rd_val;
  logic signed [31:0]   cell_val [CAPACITY];

  // output register parts the two sides; stall only while it is held
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign full    = (count_r == CAP_C);
  assign pos_ext = PW'(in_data.position);
  assign cnt_ext = PW'(count_r);

  // read tap: only the first 32 slots are reachable by a 5-bit position
  always_comb begin
    rd_val = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_data.position == iarl_pkg::POS_W'(k)) begin
        rd_val = cell_val[k];
      end
    end
  end

  // operation decode, status and new length
  always_comb begin
    logic [1:0]         st;
    logic signed [31:0] rv;
    st        = iarl_pkg::ST_OK;
    rv        = '0;
    ctl       = '0;
    at        = '0;
    count_nxt = count_r;
    case (in_data.opcode)
      iarl_pkg::OP_APPEND: begin
        if (full) begin
          st = iarl_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          at      = count_r;
        end
      end
      iarl_pkg::OP_PREPEND: begin
        if (full) begin
          st = iarl_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      iarl_pkg::OP_INSERT: begin
        // full check wins over the range check
        if (full) begin
          st = iarl_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          st = iarl_pkg::ST_RANGE;
        end else begin
          ctl.ins = 1'b1;
          at      = CW'(pos_ext);
        end
      end
      iarl_pkg::OP_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          st = iarl_pkg::ST_RANGE;
        end else begin
          ctl.rem = 1'b1;
          at      = CW'(pos_ext);
        end
      end
      iarl_pkg::OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          st = iarl_pkg::ST_RANGE;
        end else begin
          rv = rd_val;
        end
      end
      default: begin
        // unused opcodes leave the list alone and answer ok
      end
    endcase
    if (!accept) begin
      ctl = '0;
    end
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CW'(1);
    end
    out_data_nxt.status      = st;
    out_data_nxt.read_value  = rv;
    out_data_nxt.list_length = iarl_pkg::LEN_W'(count_nxt);
  end

  // row of cells, each slot talks to the one below and the one above
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower_val;
    logic signed [31:0] upper_val;
    if (i == 0) begin : g_lo_edge
      assign lower_val = '0;
    end else begin : g_lo
      assign lower_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_edge
      assign upper_val = '0;
    end else begin : g_hi
      assign upper_val = cell_val[i+1];
    end
    iarl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .at        (at),
      .cnt       (count_r),
      .word      (in_data.data_value),
      .lower_val (lower_val),
      .upper_val (upper_val),
      .val       (cell_val[i])
    );
  end

  // result held until taken, a new word may land the same cycle it leaves
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking bench for indexed_array_list, a fixed-capacity list of signed words
// depends on iarl_pkg and indexed_array_list; a local list mirror predicts every result word
module testbench;

  localparam int LIST_CAP = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 620;
  localparam int CALM_TAIL = 60;          // last words of the run go without idling
  localparam logic [2:0] OP_LAST = 3'd7;  // top of the opcode field, 5..7 are unused

  // one staged input word, optionally held back until the list has answered everything
  typedef struct {
    iarl_pkg::in_word_t word;
    bit                 drain;
  } staged_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  iarl_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  iarl_pkg::out_word_t out_data;

  staged_t             item_q[$];       // words waiting to be offered
  iarl_pkg::out_word_t want_q[$];       // predicted result words, oldest first

  // list mirror used for prediction
  logic signed [31:0] mirror_mem [LIST_CAP];
  int                 mirror_len = 0;

  int          err_count = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          idle_cycles = 0;
  logic [31:0] cyc = '0;
  int          gen_len = 0;   // list length as seen by the stimulus generator

  indexed_array_list #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < LIST_CAP; i++) mirror_mem[i] = '0;
  end

  // apply one word to the mirror and return the result word the list should give
  function automatic iarl_pkg::out_word_t list_apply(input iarl_pkg::in_word_t w);
    iarl_pkg::out_word_t r;
    int                  p;
    int                  i;
    bit                  is_full;
    r = '0;
    r.status = iarl_pkg::ST_OK;
    p = w.position;
    is_full = (mirror_len >= LIST_CAP);
    case (w.opcode)
      iarl_pkg::OP_APPEND, iarl_pkg::OP_PREPEND, iarl_pkg::OP_INSERT: begin
        if (w.opcode == iarl_pkg::OP_APPEND) p = mirror_len;
        else if (w.opcode == iarl_pkg::OP_PREPEND) p = 0;
        // full is checked ahead of the position
        if (is_full) r.status = iarl_pkg::ST_FULL;
        else if (p > mirror_len) r.status = iarl_pkg::ST_RANGE;
        else begin
          for (i = mirror_len; i > p; i--) mirror_mem[i] = mirror_mem[i - 1];
          mirror_mem[p] = w.data_value;
          mirror_len++;
        end
      end
      iarl_pkg::OP_REMOVE: begin
        if (p >= mirror_len) r.status = iarl_pkg::ST_RANGE;
        else begin
          for (i = p; i + 1 < mirror_len; i++) mirror_mem[i] = mirror_mem[i + 1];
          // vacated top slot goes back to zero
          mirror_mem[mirror_len - 1] = '0;
          mirror_len--;
        end
      end
      iarl_pkg::OP_READ: begin
        if (p >= mirror_len) r.status = iarl_pkg::ST_RANGE;
        else r.read_value = mirror_mem[p];
      end
      default: begin
        // unused opcodes leave the list alone
      end
    endcase
    r.list_length = mirror_len[iarl_pkg::LEN_W-1:0];
    return r;
  endfunction

  // queue a word and keep the generator's idea of the length in step
  task automatic stage_word(input logic [2:0] op, input logic signed [31:0] data,
                            input int pos, input bit drain = 1'b0);
    staged_t s;
    s.word.opcode = op;
    s.word.data_value = data;
    s.word.position = pos[iarl_pkg::POS_W-1:0];
    s.drain = drain;
    item_q.push_back(s);
    case (op)
      iarl_pkg::OP_APPEND, iarl_pkg::OP_PREPEND: if (gen_len < LIST_CAP) gen_len++;
      iarl_pkg::OP_INSERT: if (gen_len < LIST_CAP && pos <= gen_len) gen_len++;
      iarl_pkg::OP_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // stimulus: directed corner words, then random words in grow / shrink / mixed phases
  initial begin
    int  bias;
    int  r;
    int  pos;
    logic [2:0] op;
    logic signed [31:0] data;

    // empty list: reads, removes and inserts past the end all miss, unused opcodes answer ok
    stage_word(iarl_pkg::OP_READ, 32'sd0, 0);
    stage_word(iarl_pkg::OP_REMOVE, 32'sd0, 0);
    stage_word(iarl_pkg::OP_INSERT, 32'sd7, 1);
    for (int k = iarl_pkg::OP_READ + 1; k <= OP_LAST; k++) stage_word(k[2:0], 32'sd0, 0);

    // fill with the data extremes at both ends and in the middle
    stage_word(iarl_pkg::OP_INSERT, 32'sh8000_0000, 0);
    stage_word(iarl_pkg::OP_PREPEND, 32'sh7fff_ffff, 0);
    stage_word(iarl_pkg::OP_APPEND, 32'sd0, 0);
    stage_word(iarl_pkg::OP_INSERT, -32'sd1, 1);
    stage_word(iarl_pkg::OP_INSERT, 32'sh5555_5555, gen_len);   // insert at the end appends
    while (gen_len < LIST_CAP)
      stage_word(iarl_pkg::OP_INSERT, $urandom, $urandom_range(0, gen_len));

    // full list: every growing opcode is refused, full beats an out-of-range insert
    stage_word(iarl_pkg::OP_APPEND, 32'sh2aaa_aaaa, 0);
    stage_word(iarl_pkg::OP_PREPEND, 32'sh1234_5678, 0);
    stage_word(iarl_pkg::OP_INSERT, 32'sh0f0f_0f0f, 31);
    stage_word(iarl_pkg::OP_READ, 32'sd0, LIST_CAP - 1);
    // remove at the length is out of range; hold off here until the list has caught up
    stage_word(iarl_pkg::OP_REMOVE, 32'sd0, LIST_CAP, 1'b1);
    stage_word(iarl_pkg::OP_REMOVE, 32'sd0, 0);
    stage_word(iarl_pkg::OP_REMOVE, 32'sd0, gen_len - 1);

    bias = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) bias = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (bias)
        0: op = (r < 25) ? iarl_pkg::OP_APPEND : (r < 40) ? iarl_pkg::OP_PREPEND :
                (r < 75) ? iarl_pkg::OP_INSERT : (r < 85) ? iarl_pkg::OP_READ :
                (r < 95) ? iarl_pkg::OP_REMOVE : OP_LAST;
        1: op = (r < 8) ? iarl_pkg::OP_APPEND : (r < 14) ? iarl_pkg::OP_PREPEND :
                (r < 24) ? iarl_pkg::OP_INSERT : (r < 44) ? iarl_pkg::OP_READ :
                (r < 94) ? iarl_pkg::OP_REMOVE : OP_LAST;
        default: op = (r < 20) ? iarl_pkg::OP_APPEND : (r < 30) ? iarl_pkg::OP_PREPEND :
                      (r < 50) ? iarl_pkg::OP_INSERT : (r < 75) ? iarl_pkg::OP_READ :
                      (r < 95) ? iarl_pkg::OP_REMOVE : OP_LAST;
      endcase
      if (op == OP_LAST) op = 3'($urandom_range(iarl_pkg::OP_READ + 1, OP_LAST));
      // mostly legal positions including the length itself, now and then anything
      pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, gen_len);
      case ($urandom_range(0, 15))
        0: data = 32'sh8000_0000;
        1: data = 32'sh7fff_ffff;
        2: data = -32'sd1;
        default: data = $urandom;
      endcase
      stage_word(op, data, pos, (n % 150 == 75));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to go in and every result to come back
    while (item_q.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // driver: predict on acceptance, then present the next word or idle for a burst
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) want_q.push_back(list_apply(in_data));
      // a stalled word stays put
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (item_q.size() == 0 || (item_q[0].drain && want_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (item_q.size() > CALM_TAIL && cyc[7:6] != 2'd0 &&
                     $urandom_range(0, 6) == 0) begin
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 8);
        end else begin
          in_data <= item_q[0].word;
          in_valid <= 1'b1;
          void'(item_q.pop_front());
        end
      end
    end
  end

  // monitor: compare each taken result word with the oldest prediction, stall in bursts
  always @(posedge clk) begin
    iarl_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("result word with nothing expected: %p", out_data);
          err_count++;
        end else begin
          want = want_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            err_count++;
          end
          if (out_data.list_length !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length,
                   out_data.list_length);
            err_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (item_q.size() > CALM_TAIL && cyc[8:7] != 2'd0 &&
                   $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without a word moving on either side ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
